[sv/tws_pkg.sv]
// ----------------------------------------------------------------------------
// tws_pkg
// shared types, widths and constants of the temperature window statistics unit
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  localparam int unsigned Window   = 60;
  localparam int unsigned SlotW    = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned HeldW    = $clog2(Window + 1);
  localparam int unsigned SumW     = $clog2(Window * 255 + 1);
  localparam int unsigned CntW     = (SumW > 1) ? $clog2(SumW) : 1;

  localparam int unsigned AdcW     = 10;
  localparam int unsigned TempW    = 8;
  localparam int unsigned DivW     = 8;
  localparam int unsigned ScaleW   = 7;
  localparam int unsigned ProdW    = AdcW + ScaleW;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  localparam logic [ScaleW-1:0] TempScale     = ScaleW'(125);
  localparam int unsigned       TempShift     = 8;
  localparam logic [TempW-1:0]  TempMax       = 8'hFF;
  localparam logic [TempW-1:0]  LowestReset   = TempW'(125);
  localparam logic [DivW-1:0]   DivisorReset  = DivW'(62);

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_CONV = 1'b1
  } tws_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_PUBLISH
  } tws_state_e;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic update;
    logic div_step;
    logic load_out;
  } tws_cmd_t;

  typedef struct packed {
    logic take;
    logic div_done;
    logic out_free;
  } tws_sts_t;

endpackage

`default_nettype wire

[sv/tws_ram.sv]
// ----------------------------------------------------------------------------
// tws_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 60
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/tws_ctrl.sv]
// ----------------------------------------------------------------------------
// tws_ctrl
// sequencer: accept, window read, update, divide, publish
// ----------------------------------------------------------------------------
`default_nettype none

module tws_ctrl
  import tws_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire tws_sts_t sts_i,
  output tws_cmd_t      cmd_o
);

  tws_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.take ? ST_READ : ST_PUBLISH;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          state_d = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_READ:    cmd_o.rd_en    = 1'b1;
      ST_UPDATE:  cmd_o.update   = 1'b1;
      ST_DIVIDE:  cmd_o.div_step = 1'b1;
      ST_PUBLISH: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[sv/tws_dp.sv]
// ----------------------------------------------------------------------------
// tws_dp
// datapath: tick divider, temperature scaling, min/max, window sum,
// bit-serial divider and output register
// ----------------------------------------------------------------------------
`default_nettype none

module tws_dp
  import tws_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [DivW-1:0]     cfg_wdata_i,
  input  wire logic                in_kind_i,
  input  wire logic [AdcW-1:0]     in_adc_i,
  input  wire tws_cmd_t            cmd_i,
  output tws_sts_t                 sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic                     out_taken_o,
  output logic [OutDataW-1:0]      out_data_o
);

  logic [DivW-1:0]   divisor_q;
  logic [DivW-1:0]   tick_q;
  logic              armed_q;
  logic              take_q;
  logic [TempW-1:0]  temp_q;
  logic [SlotW-1:0]  slot_q;
  logic [HeldW-1:0]  held_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [TempW-1:0]  latest_q, highest_q, lowest_q, mean_q, mean_d;
  logic [SumW-1:0]   quo_q;
  logic [HeldW-1:0]  rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;
  logic              out_taken_q;
  logic [OutDataW-1:0] out_data_q;

  logic [DivW-1:0]   tick_inc;
  logic [ProdW-1:0]  prod;
  logic [ProdW-TempShift-1:0] scaled;
  logic [TempW-1:0]  temp_d;
  logic [TempW-1:0]  old_temp;
  logic              window_full;
  logic [HeldW:0]    rem_shift;
  logic              rem_ge;
  logic [HeldW:0]    rem_sub;
  logic              take_now;

  tws_ram #(
    .Width (TempW),
    .Depth (Window)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (slot_q),
    .wdata_i (temp_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (slot_q),
    .rdata_o (old_temp)
  );

  // temperature scaling, floor(adc*125/256) saturated
  assign prod   = ProdW'(in_adc_i) * ProdW'(TempScale);
  assign scaled = prod[ProdW-1:TempShift];
  assign temp_d = (scaled > (ProdW-TempShift)'(TempMax)) ? TempMax : scaled[TempW-1:0];

  assign tick_inc = tick_q + DivW'(1);
  assign take_now = (tws_kind_e'(in_kind_i) == KIND_CONV) && armed_q;

  assign window_full = (held_q >= HeldW'(Window));
  always_comb begin
    if (window_full) begin
      sum_d = sum_q - SumW'(old_temp) + SumW'(temp_q);
    end else begin
      sum_d = sum_q + SumW'(temp_q);
    end
  end

  // restoring divider step
  assign rem_shift = {rem_q, quo_q[SumW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, held_q});
  assign rem_sub   = rem_shift - {1'b0, held_q};

  assign mean_d = take_q ? quo_q[TempW-1:0] : mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DivisorReset;
    end else if (cfg_we_i) begin
      divisor_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      armed_q     <= 1'b0;
      take_q      <= 1'b0;
      slot_q      <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      latest_q    <= '0;
      highest_q   <= '0;
      lowest_q    <= LowestReset;
      mean_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        take_q <= take_now;
        if (tws_kind_e'(in_kind_i) == KIND_TICK) begin
          if (tick_inc == divisor_q) begin
            tick_q  <= '0;
            armed_q <= 1'b1;
          end else begin
            tick_q <= tick_inc;
          end
        end else if (armed_q) begin
          armed_q <= 1'b0;
        end
      end
      if (cmd_i.update) begin
        latest_q <= temp_q;
        if (temp_q < lowest_q) begin
          lowest_q <= temp_q;
        end
        if (temp_q > highest_q) begin
          highest_q <= temp_q;
        end
        if (!window_full) begin
          held_q <= held_q + HeldW'(1);
        end
        sum_q <= sum_d;
        if (slot_q == SlotW'(Window - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + SlotW'(1);
        end
        cnt_q <= CntW'(SumW - 1);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.load_out) begin
        mean_q      <= mean_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      temp_q <= temp_d;
    end
    if (cmd_i.update) begin
      quo_q <= sum_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SumW-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[HeldW-1:0] : rem_shift[HeldW-1:0];
    end
    if (cmd_i.load_out) begin
      out_taken_q <= take_q;
      out_data_q  <= {mean_d, lowest_q, highest_q, latest_q};
    end
  end

  assign sts_o.take     = take_now;
  assign sts_o.div_done = (cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_taken_o = out_taken_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[sv/temperature_window_statistics_unit.sv]
// sequence: a tick or unarmed conversion goes from acceptance straight to publish
// sampled conversion: acceptance, then window read,
//   update, 14-step bit-serial divide of the window sum, publish
// flow: one transaction at a time; publish waits while the previous result
//   is held by a low m_axis_tready
// reset: asynchronous active low; divider 62, statistics cleared, min 125
// ----------------------------------------------------------------------------
// temperature_window_statistics_unit
// timer-gated temperature sampling with min, max and sliding-window average
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_window_statistics_unit
  import tws_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [DivW-1:0]     cfg_wdata_i,    // tick_divisor
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [9:0] adc_value
  input  wire logic                s_axis_tuser,   // [0] cmd
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [7:0] current_temp, [15:8] max_temp,
                                                   // [23:16] min_temp, [31:24] avg_temp
  output logic                     m_axis_tuser    // [0] sample_taken
);

  tws_cmd_t cmd;
  tws_sts_t sts;

  tws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_adc_i    (s_axis_tdata[AdcW-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_taken_o (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[sv/tws_checker.sv]
// ----------------------------------------------------------------------------
// tws_checker
// port-level checks of the temperature window statistics unit
// ----------------------------------------------------------------------------
`default_nettype none

module tws_checker
  import tws_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tuser
);

  // stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one transaction in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a taken sample lies between min and max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[7:0] >= m_axis_tdata[23:16] && m_axis_tdata[7:0] <= m_axis_tdata[15:8])
    else $error("current temperature outside min/max");

  // window average lies between min and max once sampled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[31:24] >= m_axis_tdata[23:16] && m_axis_tdata[31:24] <= m_axis_tdata[15:8])
    else $error("average outside min/max");

endmodule

bind temperature_window_statistics_unit tws_checker u_tws_checker (.*);

`default_nettype wire

[tb/temperature_window_statistics_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// temperature_window_statistics_unit_tb
// self-checking bench: a queued stream of timer ticks and adc conversions is
// driven in random bursts, a shadow of the sampling gate, min/max tracker and
// sixty-sample sliding average predicts every result transaction, and the
// result stream is checked field by field under random back-pressure; the tick
// divisor is rewritten between phases, including zero
// ----------------------------------------------------------------------------

module temperature_window_statistics_unit_tb;
  import tws_pkg::*;

  typedef struct packed {
    tws_kind_e       kind;
    logic [AdcW-1:0] adc;
  } reading_t;

  typedef struct packed {
    logic             taken;
    logic [TempW-1:0] current;
    logic [TempW-1:0] highest;
    logic [TempW-1:0] lowest;
    logic [TempW-1:0] average;
  } stats_t;

  localparam logic [AdcW-1:0] DirectedAdc [12] = '{
    10'd300, 10'd200, 10'd250, 10'd100, 10'd400, 10'd524,
    10'd525, 10'd1023, 10'd0, 10'd1, 10'd3, 10'h2AA
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [DivW-1:0]     cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  reading_t reading_queue [$];
  stats_t   stats_due [$];
  int       err_cnt = 0;

  // shadow of the block state
  logic [DivW-1:0]  stats_div = DivisorReset;
  logic [DivW-1:0]  tick_cnt = '0;
  logic             armed = 1'b0;
  logic [TempW-1:0] window_mem [Window];
  logic [SlotW-1:0] slot = '0;
  logic [HeldW-1:0] held = '0;
  logic [SumW-1:0]  win_sum = '0;
  logic [TempW-1:0] latest = '0;
  logic [TempW-1:0] highest = '0;
  logic [TempW-1:0] lowest = LowestReset;
  logic [TempW-1:0] mean = '0;

  // arming mirror used only to build well-formed sequences
  logic [DivW-1:0]  gen_div = DivisorReset;
  logic [DivW-1:0]  gen_cnt = '0;
  logic             gen_armed = 1'b0;

  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  stall_phase = '0;

  temperature_window_statistics_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [TempW-1:0] adc_to_temp(logic [AdcW-1:0] adc);
    logic [ProdW-1:0] prod;
    logic [ProdW-TempShift-1:0] scaled;
    prod = ProdW'(adc) * ProdW'(125);
    scaled = prod[ProdW-1:TempShift];
    return (scaled > 255) ? TempMax : scaled[TempW-1:0];
  endfunction

  function void advance_stats(tws_kind_e kind, logic [AdcW-1:0] adc);
    logic [TempW-1:0] t;
    logic taken;
    taken = 1'b0;
    if (kind == KIND_TICK) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt == stats_div) begin
        tick_cnt = '0;
        armed = 1'b1;
      end
    end else if (armed) begin
      armed = 1'b0;
      taken = 1'b1;
      t = adc_to_temp(adc);
      latest = t;
      if (t < lowest) lowest = t;
      if (t > highest) highest = t;
      if (held < Window) held = held + 1'b1;
      else win_sum = win_sum - SumW'(window_mem[slot]);
      window_mem[slot] = t;
      win_sum = win_sum + SumW'(t);
      mean = TempW'(win_sum / held);
      slot = (slot == SlotW'(Window - 1)) ? '0 : slot + 1'b1;
    end
    stats_due.push_back('{taken, latest, highest, lowest, mean});
  endfunction

  task automatic push_item(tws_kind_e kind, logic [AdcW-1:0] adc);
    reading_queue.push_back('{kind, adc});
    if (kind == KIND_TICK) begin
      gen_cnt = gen_cnt + 8'd1;
      if (gen_cnt == gen_div) begin
        gen_cnt = '0;
        gen_armed = 1'b1;
      end
    end else begin
      gen_armed = 1'b0;
    end
  endtask

  task automatic arm_and_convert(logic [AdcW-1:0] adc);
    while (!gen_armed) push_item(KIND_TICK, AdcW'($urandom));
    push_item(KIND_CONV, adc);
  endtask

  function automatic logic [AdcW-1:0] pick_adc();
    case ($urandom_range(0, 7))
      0: return AdcW'($urandom_range(0, 15));
      1: return AdcW'($urandom_range(1008, 1023));
      2: return AdcW'($urandom_range(515, 535));
      default: return AdcW'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    while (reading_queue.size() != 0 || stats_due.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_divisor(logic [DivW-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stats_div = value;
    gen_div = value;
  endtask

  task automatic run_random(int n_items);
    int stop_at;
    stop_at = reading_queue.size() + n_items;
    while (reading_queue.size() < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        arm_and_convert(pick_adc());
      end else begin
        push_item(tws_kind_e'($urandom_range(0, 1)), AdcW'($urandom));
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_stats(tws_kind_e'(s_axis_tuser), s_axis_tdata[AdcW-1:0]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (reading_queue.size() > 0) begin
          item = reading_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= item.kind;
          s_axis_tdata <= InDataW'(item.adc);
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (stats_due.size() == 0) begin
          $error("result transaction with no expectation pending");
          err_cnt++;
        end else begin
          want = stats_due.pop_front();
          if (m_axis_tuser !== want.taken) begin
            $error("sample_taken: expected %0d, actual %0d", want.taken, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[7:0] !== want.current) begin
            $error("current_temp: expected %0d, actual %0d", want.current,
                   m_axis_tdata[7:0]);
            err_cnt++;
          end
          if (m_axis_tdata[15:8] !== want.highest) begin
            $error("max_temp: expected %0d, actual %0d", want.highest,
                   m_axis_tdata[15:8]);
            err_cnt++;
          end
          if (m_axis_tdata[23:16] !== want.lowest) begin
            $error("min_temp: expected %0d, actual %0d", want.lowest,
                   m_axis_tdata[23:16]);
            err_cnt++;
          end
          if (m_axis_tdata[31:24] !== want.average) begin
            $error("avg_temp: expected %0d, actual %0d", want.average,
                   m_axis_tdata[31:24]);
            err_cnt++;
          end
        end
      end
      if (stall_phase == 4'd0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      m_axis_tready <= stall_pat[stall_phase];
      stall_phase <= stall_phase + 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset divisor: unarmed conversion, one tick short, then tick while armed
    push_item(KIND_CONV, 10'd1023);
    repeat (61) push_item(KIND_TICK, AdcW'($urandom));
    push_item(KIND_CONV, 10'd700);
    push_item(KIND_TICK, 10'd0);
    push_item(KIND_TICK, 10'd1023);
    push_item(KIND_CONV, 10'd256);

    write_divisor(8'd2);
    foreach (DirectedAdc[i]) arm_and_convert(DirectedAdc[i]);
    push_item(KIND_CONV, 10'h155);
    push_item(KIND_TICK, 10'h155);
    push_item(KIND_TICK, 10'h2AA);
    push_item(KIND_CONV, 10'h155);

    write_divisor(8'd1);
    run_random(250);
    write_divisor(DivW'($urandom_range(3, 8)));
    run_random(80);

    // divisor lowered below a running count, down to zero
    write_divisor(8'd200);
    repeat (100) push_item(KIND_TICK, AdcW'($urandom));
    write_divisor(8'd0);
    arm_and_convert(pick_adc());

    wait_idle();
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tws_pkg.sv
sv/tws_ram.sv
sv/tws_ctrl.sv
sv/tws_dp.sv
sv/temperature_window_statistics_unit.sv
sv/tws_checker.sv
tb/temperature_window_statistics_unit_tb.sv
